>>> rtl/core/mcr_pkg.sv
// mcr_pkg: shared types, constants and helpers of the midpoint circle rasterizer
// used by mcr_octant and midpoint_circle_rasterizer; depends on nothing else

package mcr_pkg;

  // sizing
  localparam int COORD_BITS = 12;
  localparam int MAX_RADIUS = 63;
  localparam int RESULT_CAP = 64;
  localparam int SCREEN_CAP = 1 << (COORD_BITS - 1);

  // configuration register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PIXEL_COLOR   = 2'd2;

  // circle command word
  typedef struct packed {
    logic signed [11:0] center_x;
    logic signed [11:0] center_y;
    logic [5:0]         circle_radius;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [5:0]  offset_major;
    logic [5:0]  offset_minor;
    logic [7:0]  octant_mask;
    logic [15:0] color_out;
    logic        box_valid;
    logic [10:0] box_left;
    logic [10:0] box_top;
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic        last;
  } result_t;

  // latched circle geometry and effective screen size
  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [11:0]        w;
    logic [11:0]        h;
  } geom_t;

  // true when a coordinate lies in [0, lim)
  function automatic logic on_axis(logic signed [12:0] p, logic [11:0] lim);
    on_axis = !p[12] && (p[11:0] < lim);
  endfunction

endpackage

>>> rtl/core/mcr_octant.sv
// mcr_octant: on-screen test of the eight octant pixels of one midpoint step
// depends on mcr_pkg (geom_t, on_axis)

module mcr_octant (
  input  mcr_pkg::geom_t geom,
  input  logic [6:0]     major,
  input  logic [6:0]     minor,
  output logic [7:0]     mask
);
  import mcr_pkg::*;

  logic signed [12:0] cx_ext, cy_ext, maj_ext, min_ext;
  logic signed [12:0] col_px, col_mx, col_py, col_my;
  logic signed [12:0] row_px, row_mx, row_py, row_my;
  logic in_col_px, in_col_mx, in_col_py, in_col_my;
  logic in_row_px, in_row_mx, in_row_py, in_row_my;

  // operand extension
  assign cx_ext  = {geom.cx[11], geom.cx};
  assign cy_ext  = {geom.cy[11], geom.cy};
  assign maj_ext = $signed({6'd0, major});
  assign min_ext = $signed({6'd0, minor});

  // the eight pixel coordinates
  assign col_px = cx_ext + maj_ext;
  assign col_mx = cx_ext - maj_ext;
  assign col_py = cx_ext + min_ext;
  assign col_my = cx_ext - min_ext;
  assign row_px = cy_ext + maj_ext;
  assign row_mx = cy_ext - maj_ext;
  assign row_py = cy_ext + min_ext;
  assign row_my = cy_ext - min_ext;

  // per-axis clipping on all four sides
  assign in_col_px = on_axis(col_px, geom.w);
  assign in_col_mx = on_axis(col_mx, geom.w);
  assign in_col_py = on_axis(col_py, geom.w);
  assign in_col_my = on_axis(col_my, geom.w);
  assign in_row_px = on_axis(row_px, geom.h);
  assign in_row_mx = on_axis(row_mx, geom.h);
  assign in_row_py = on_axis(row_py, geom.h);
  assign in_row_my = on_axis(row_my, geom.h);

  // octant order k0..k7
  assign mask[0] = in_col_px && in_row_py;
  assign mask[1] = in_col_py && in_row_px;
  assign mask[2] = in_col_my && in_row_px;
  assign mask[3] = in_col_mx && in_row_py;
  assign mask[4] = in_col_mx && in_row_my;
  assign mask[5] = in_col_my && in_row_mx;
  assign mask[6] = in_col_py && in_row_mx;
  assign mask[7] = in_col_px && in_row_my;

endmodule

>>> rtl/core/midpoint_circle_rasterizer.sv
// midpoint_circle_rasterizer: top level, command sequencer and midpoint step unit
// depends on mcr_pkg and mcr_octant

// Usage:
// - in channel (in_valid/in_ready/in_data) takes one circle command word:
//   signed center and radius. in_ready is high only while no circle runs.
// - out channel (out_valid/out_ready/out_data) gives one word per midpoint
//   step: offsets, octant on-screen mask and color; the final word of a
//   circle has last set and carries the clamped dirty box if it is on screen.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes screen
//   width, screen height and pixel color; cfg_ready is always high and
//   writes are meant for idle periods only.
// - timing: after the command is accepted the sequencer passes through
//   ST_BOX to ST_RUN, where the single midpoint step unit gives one word
//   per cycle while the receiver takes them.
// - the output register decouples the sides: the next command is taken
//   while the last word of the previous circle still waits.
// - a stalled receiver freezes the step unit; the word on out_data holds.
// - reset (rst, synchronous) returns to idle with no word pending and the
//   registers at 320 x 240, color 0xFFFF.

module midpoint_circle_rasterizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcr_pkg::cmd_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mcr_pkg::result_t  out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import mcr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BOX  = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t state;

  logic [11:0] screen_width, screen_height;
  logic [15:0] pixel_color;

  geom_t       geom;
  logic [6:0]  iter_major, iter_minor;
  logic signed [8:0] iter_error;
  logic [5:0]  count;

  logic signed [12:0] box_minx, box_maxx, box_miny, box_maxy;

  logic [11:0] w_eff, h_eff;
  logic [5:0]  radius_sat;

  logic signed [8:0] err_add, err_next;
  logic signed [9:0] err_twice;
  logic        step_down, cont, last_step, load;
  logic [6:0]  major_next, minor_next;
  logic [7:0]  mask;

  logic        box_ok;
  logic [11:0] cminx, cmaxx, cminy, cmaxy;
  result_t     word;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd320;
      screen_height <= 12'd240;
      pixel_color   <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        REG_PIXEL_COLOR:   pixel_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective screen size and radius limit
  assign w_eff = (screen_width > 12'(SCREEN_CAP)) ? 12'(SCREEN_CAP) : screen_width;
  assign h_eff = (screen_height > 12'(SCREEN_CAP)) ? 12'(SCREEN_CAP) : screen_height;
  assign radius_sat = (in_data.circle_radius > 6'(MAX_RADIUS)) ?
                      6'(MAX_RADIUS) : in_data.circle_radius;

  // midpoint step unit
  assign err_add    = iter_error + $signed({2'd0, iter_minor});
  assign err_twice  = {err_add, 1'b0};
  assign step_down  = err_twice >= $signed({3'd0, iter_major});
  assign err_next   = step_down ? (err_add - $signed({2'd0, iter_major})) : err_add;
  assign major_next = step_down ? (iter_major - 7'd1) : iter_major;
  assign minor_next = iter_minor + 7'd1;
  assign cont       = step_down ? ({1'b0, iter_major} >= ({1'b0, iter_minor} + 8'd2))
                                : (iter_major > iter_minor);
  assign last_step  = !cont || (count == 6'(RESULT_CAP - 1));

  // octant clipping lanes
  mcr_octant u_octant (
    .geom  (geom),
    .major (iter_major),
    .minor (iter_minor),
    .mask  (mask)
  );

  // dirty box clamp
  assign box_ok = (geom.w != 12'd0) && (geom.h != 12'd0) &&
                  !box_maxx[12] && !box_maxy[12] &&
                  !(!box_minx[12] && (box_minx[11:0] >= geom.w)) &&
                  !(!box_miny[12] && (box_miny[11:0] >= geom.h));
  assign cminx = box_minx[12] ? 12'd0 : box_minx[11:0];
  assign cminy = box_miny[12] ? 12'd0 : box_miny[11:0];
  assign cmaxx = (box_maxx[11:0] >= geom.w) ? (geom.w - 12'd1) : box_maxx[11:0];
  assign cmaxy = (box_maxy[11:0] >= geom.h) ? (geom.h - 12'd1) : box_maxy[11:0];

  // result word assembly
  always_comb begin
    word              = '0;
    word.offset_major = iter_major[5:0];
    word.offset_minor = iter_minor[5:0];
    word.octant_mask  = mask;
    word.color_out    = pixel_color;
    word.last         = last_step;
    if (last_step && box_ok) begin
      word.box_valid  = 1'b1;
      word.box_left   = cminx[10:0];
      word.box_top    = cminy[10:0];
      word.box_width  = cmaxx - cminx + 12'd1;
      word.box_height = cmaxy - cminy + 12'd1;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign load     = (state == ST_RUN) && (!out_valid || out_ready);

  // sequencer and iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid && in_ready) state <= ST_BOX;
        ST_BOX:  state <= ST_RUN;
        ST_RUN:  if (load && last_step) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      geom.cx    <= in_data.center_x;
      geom.cy    <= in_data.center_y;
      geom.w     <= w_eff;
      geom.h     <= h_eff;
      iter_major <= {1'b0, radius_sat};
      iter_minor <= 7'd0;
      iter_error <= 9'sd0;
      count      <= 6'd0;
    end else if (load) begin
      iter_major <= major_next;
      iter_minor <= minor_next;
      iter_error <= err_next;
      count      <= count + 6'd1;
    end
  end

  // box extents, registered in ST_BOX from the latched command
  always_ff @(posedge clk) begin
    if (state == ST_BOX) begin
      box_minx <= {geom.cx[11], geom.cx} - $signed({6'd0, iter_major});
      box_maxx <= {geom.cx[11], geom.cx} + $signed({6'd0, iter_major});
      box_miny <= {geom.cy[11], geom.cy} - $signed({6'd0, iter_major});
      box_maxy <= {geom.cy[11], geom.cy} + $signed({6'd0, iter_major});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word;
    end
  end

`ifndef SYNTH
  // the step unit only runs while the midpoint condition holds
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (iter_major >= iter_minor))
    else $error("midpoint step running with minor above major");

  // box fields only on the final word
  a_box_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (!out_data.box_valid && out_data.box_width == 12'd0))
    else $error("box data on a word that is not last");

  // a valid box is never empty
  a_box_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.box_valid) |->
      (out_data.box_width != 12'd0 && out_data.box_height != 12'd0))
    else $error("valid box with zero size");
`endif

endmodule
